// ===== rtl/core/rpq_pkg.sv =====
// shared types and constants for the priority run queue picker
`default_nettype none
package rpq_pkg;
    localparam int unsigned QUEUE_DEPTH_DEF = 32;
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_INC = 32'd12345;
    localparam logic [6:0]  MIN_PRIO_RST = 7'd0;
    localparam logic [6:0]  MAX_PRIO_RST = 7'd120;
    localparam logic [6:0]  IDLE_PRIO_RST = 7'd0;
    localparam logic [6:0]  RT_FLOOR_RST = 7'd100;
    localparam logic [14:0] SKIP_THR_RST = 15'h3000;
    localparam logic [31:0] SEED_RST = 32'd1;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_RESCHED = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_MIN_PRIO  = 3'd0,
        CFG_MAX_PRIO  = 3'd1,
        CFG_IDLE_PRIO = 3'd2,
        CFG_RT_FLOOR  = 3'd3,
        CFG_SKIP_THR  = 3'd4,
        CFG_SEED      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] thread_tag;
        logic [7:0]  priority_req;
        logic        requeue;
    } t_in_item;

    typedef struct packed {
        logic [15:0] picked_tag;
        logic [6:0]  picked_priority;
        logic [1:0]  status;
        logic [5:0]  queue_count;
    } t_out_item;

    typedef struct packed {
        logic [15:0] tag;
        logic [6:0]  prio;
    } t_entry;

    typedef struct packed {
        logic mul;
        logic add;
    } t_lcg_ctrl;
endpackage
`default_nettype wire

// ===== rtl/core/rpq_ram.sv =====
// generic single write, single read ram with registered read
`default_nettype none
module rpq_ram #(
    parameter int unsigned W = 8,
    parameter int unsigned D = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/rpq_lcg.sv =====
// linear congruential generator, multiply and add in separate cycles
`default_nettype none
module rpq_lcg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rpq_pkg::t_lcg_ctrl i_ctrl,
    input  wire logic [31:0]       i_seed,
    output logic      [14:0]       o_rnd
);
    import rpq_pkg::*;

    logic [31:0] r_value;
    logic [31:0] r_prod;
    logic [31:0] n_value;
    logic [31:0] w_base;
    logic [63:0] w_full;

    assign w_base  = (r_value == 32'd0) ? i_seed : r_value;
    assign w_full  = w_base * LCG_MUL;
    assign n_value = r_prod + LCG_INC;
    // output of the step being completed this cycle
    assign o_rnd   = n_value[30:16];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= w_full[31:0];
        end
        if (!i_rst_n) begin
            r_value <= 32'd0;
        end else if (i_ctrl.add) begin
            r_value <= n_value;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/priority_run_queue_picker_unit.sv =====
// top level: run queue sequencer around the entry ram
// Run queue picker holding up to QUEUE_DEPTH thread tags in one entry ram, sorted by
// descending priority and first-in first-out among equals. One command is worked at a time,
// each ram read answered in the cycle after it. An enqueue shifts the tail back one entry at
// a time (a read, then a write) until its slot is found. A remove scans from the head, a
// read and a check per entry, and then closes the gap, a read and a write per entry. A
// reschedule adds its optional enqueue, then walks from the head; each skipped entry takes
// four steps (ram read, next entry check, the generator's multiply and add), and the pick
// closes the gap like a remove.
// A result waits in an output register; the next command is taken once the sequencer is idle.
`default_nettype none
module priority_run_queue_picker_unit #(
    parameter int unsigned QUEUE_DEPTH = rpq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rpq_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rpq_pkg::t_out_item      o_out
);
    import rpq_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_WR, S_REM_RD, S_REM_CHK, S_DEL_RD, S_DEL_WR,
        S_PK_START, S_PK_HEAD, S_PK_TEST, S_PK_NXT, S_PK_MUL, S_PK_ADD, S_DONE
    } t_state;

    t_state        r_state;
    logic [6:0]    r_min, r_max, r_idle, r_rt;
    logic [14:0]   r_thr;
    logic [31:0]   r_seed;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    t_in_item      r_cmd;
    t_entry        r_new;
    t_entry        r_cur;
    t_entry        r_nxt;
    logic [15:0]   r_pk_tag;
    logic [6:0]    r_pk_prio;
    t_status       r_status;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_entry        w_wdata, w_rdata;
    t_lcg_ctrl     w_lcg;
    logic [14:0]   w_rnd;
    logic [7:0]    w_p0, w_p1;
    logic [CW-1:0] w_idx_inc;

    rpq_ram #(.W($bits(t_entry)), .D(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    rpq_lcg u_lcg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_lcg),
        .i_seed (r_seed),
        .o_rnd  (w_rnd)
    );

    // clamp: max first, then min
    assign w_p0 = (i_in.priority_req > {1'b0, r_max}) ? {1'b0, r_max} : i_in.priority_req;
    assign w_p1 = (w_p0 < {1'b0, r_min}) ? {1'b0, r_min} : w_p0;
    assign w_idx_inc = r_idx + 1'b1;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = r_new;
        w_raddr = r_idx[AW-1:0];
        w_lcg   = '0;
        unique case (r_state)
            S_INS_RD: begin
                w_raddr = AW'(r_idx - 1'b1);
                w_we    = (r_idx == '0);
            end
            S_INS_WR: begin
                w_we    = 1'b1;
                w_wdata = (w_rdata.prio < r_new.prio) ? w_rdata : r_new;
            end
            S_DEL_RD: begin
                w_raddr = w_idx_inc[AW-1:0];
            end
            S_DEL_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
            end
            // head read for the walk
            S_PK_START: begin
                w_raddr = '0;
            end
            S_PK_TEST: begin
                w_raddr = w_idx_inc[AW-1:0];
            end
            S_PK_MUL: w_lcg.mul = 1'b1;
            S_PK_ADD: w_lcg.add = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= MIN_PRIO_RST;
            r_max       <= MAX_PRIO_RST;
            r_idle      <= IDLE_PRIO_RST;
            r_rt        <= RT_FLOOR_RST;
            r_thr       <= SKIP_THR_RST;
            r_seed      <= SEED_RST;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_PRIO:  r_min  <= i_cfg_data[6:0];
                    CFG_MAX_PRIO:  r_max  <= i_cfg_data[6:0];
                    CFG_IDLE_PRIO: r_idle <= i_cfg_data[6:0];
                    CFG_RT_FLOOR:  r_rt   <= i_cfg_data[6:0];
                    CFG_SKIP_THR:  r_thr  <= i_cfg_data[14:0];
                    CFG_SEED:      r_seed <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd      <= i_in;
                        r_new      <= '{tag: i_in.thread_tag, prio: w_p1[6:0]};
                        r_pk_tag   <= '0;
                        r_pk_prio  <= '0;
                        r_status   <= ST_OK;
                        r_idx      <= r_count;
                        priority case (1'b1)
                            (i_in.command == CMD_ENQUEUE) ||
                            (i_in.command == CMD_RESCHED && i_in.requeue): begin
                                if (r_count == DEPTH_C) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_INS_RD;
                                end
                            end
                            i_in.command == CMD_REMOVE: begin
                                r_idx   <= '0;
                                r_state <= S_REM_RD;
                            end
                            i_in.command == CMD_RESCHED: r_state <= S_PK_START;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (r_idx == '0) begin
                        r_count <= r_count + 1'b1;
                        r_state <= (r_cmd.command == CMD_RESCHED) ? S_PK_START : S_DONE;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    if (w_rdata.prio < r_new.prio) begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= (r_cmd.command == CMD_RESCHED) ? S_PK_START : S_DONE;
                    end
                end
                S_REM_RD: begin
                    if (r_idx == r_count) begin
                        r_status <= ST_MISSING;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_REM_CHK;
                    end
                end
                S_REM_CHK: begin
                    if (w_rdata.tag == r_cmd.thread_tag) begin
                        r_state <= S_DEL_RD;
                    end else begin
                        r_idx   <= w_idx_inc;
                        r_state <= S_REM_RD;
                    end
                end
                S_DEL_RD: begin
                    if (w_idx_inc >= r_count) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    r_idx   <= w_idx_inc;
                    r_state <= S_DEL_RD;
                end
                S_PK_START: begin
                    r_idx <= '0;
                    if (r_count == '0) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_PK_HEAD;
                    end
                end
                S_PK_HEAD: begin
                    r_cur   <= w_rdata;
                    r_state <= S_PK_TEST;
                end
                S_PK_TEST: begin
                    if (r_cur.prio <= r_idle || r_cur.prio >= r_rt || w_idx_inc >= r_count) begin
                        r_pk_tag  <= r_cur.tag;
                        r_pk_prio <= r_cur.prio;
                        r_state   <= S_DEL_RD;
                    end else begin
                        r_state <= S_PK_NXT;
                    end
                end
                S_PK_NXT: begin
                    r_nxt <= w_rdata;
                    if (w_rdata.prio == r_idle) begin
                        r_pk_tag  <= r_cur.tag;
                        r_pk_prio <= r_cur.prio;
                        r_state   <= S_DEL_RD;
                    end else begin
                        r_state <= S_PK_MUL;
                    end
                end
                S_PK_MUL: r_state <= S_PK_ADD;
                S_PK_ADD: begin
                    if (w_rnd > r_thr) begin
                        r_pk_tag  <= r_cur.tag;
                        r_pk_prio <= r_cur.prio;
                        r_state   <= S_DEL_RD;
                    end else begin
                        r_cur   <= r_nxt;
                        r_idx   <= w_idx_inc;
                        r_state <= S_PK_TEST;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid           <= 1'b1;
                        o_out.picked_tag      <= r_pk_tag;
                        o_out.picked_priority <= r_pk_prio;
                        o_out.status          <= r_status;
                        o_out.queue_count     <= 6'(r_count);
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rpq_checker.sv =====
// port level checks for the run queue picker, bound to the top level
`default_nettype none
module rpq_checker #(
    parameter int unsigned QUEUE_DEPTH = rpq_pkg::QUEUE_DEPTH_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire rpq_pkg::t_out_item o_out
);
    import rpq_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result beat changed under stall");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second command taken while busy");

    a_pick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.picked_tag != 16'd0 |-> o_out.status == ST_OK)
        else $error("pick reported with error status");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_EMPTY |-> o_out.queue_count == 6'd0)
        else $error("empty status with entries left");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |-> o_out.queue_count == 6'(QUEUE_DEPTH))
        else $error("full status below depth");
endmodule

bind priority_run_queue_picker_unit rpq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rpq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);
`default_nettype wire

// ===== test/rpq_checker.sv =====
// checker: watches both channels, predicts each result and compares it
`timescale 1ns / 100ps
`default_nettype none
module rpq_scoreboard (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire rpq_pkg::t_in_item  i_in,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire rpq_pkg::t_out_item i_out,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_picks
);
    import rpq_pkg::*;

    localparam int DEPTH = 32;

    logic [6:0]  min_prio, max_prio, idle_prio, rt_floor;
    logic [14:0] skip_thr;
    logic [31:0] seed, lcg;
    logic [15:0] q_tag [DEPTH];
    logic [6:0]  q_prio [DEPTH];
    int          q_len;
    t_out_item   expected_results [$];

    function automatic logic [14:0] lcg_next();
        if (lcg == 32'd0) begin
            lcg = seed;
        end
        lcg = lcg * 32'd1103515245 + 32'd12345;
        return lcg[30:16];
    endfunction

    function automatic logic queue_insert(logic [15:0] tag, logic [7:0] req);
        logic [7:0] p;
        int pos;
        p = req;
        if (p > {1'b0, max_prio}) p = {1'b0, max_prio};
        if (p < {1'b0, min_prio}) p = {1'b0, min_prio};
        if (q_len >= DEPTH) return 1'b0;
        pos = 0;
        while (pos < q_len && q_prio[pos] >= p[6:0]) pos++;
        for (int i = q_len; i > pos; i--) begin
            q_tag[i] = q_tag[i-1];
            q_prio[i] = q_prio[i-1];
        end
        q_tag[pos] = tag;
        q_prio[pos] = p[6:0];
        q_len++;
        return 1'b1;
    endfunction

    function automatic void queue_delete(int pos);
        for (int i = pos; i + 1 < q_len; i++) begin
            q_tag[i] = q_tag[i+1];
            q_prio[i] = q_prio[i+1];
        end
        q_len--;
    endfunction

    function automatic t_out_item run_command(t_in_item it);
        t_out_item r;
        int pos;
        r = '0;
        r.status = ST_OK;
        case (it.command)
            CMD_ENQUEUE: begin
                if (!queue_insert(it.thread_tag, it.priority_req)) r.status = ST_FULL;
            end
            CMD_REMOVE: begin
                pos = 0;
                while (pos < q_len && q_tag[pos] != it.thread_tag) pos++;
                if (pos < q_len) queue_delete(pos);
                else r.status = ST_MISSING;
            end
            CMD_RESCHED: begin
                if (it.requeue && !queue_insert(it.thread_tag, it.priority_req)) begin
                    r.status = ST_FULL;
                end else if (q_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    forever begin
                        if (q_prio[pos] <= idle_prio || q_prio[pos] >= rt_floor) break;
                        if (pos + 1 >= q_len) break;
                        if (q_prio[pos+1] == idle_prio) break;
                        if (lcg_next() > skip_thr) break;
                        pos++;
                    end
                    r.picked_tag = q_tag[pos];
                    r.picked_priority = q_prio[pos];
                    queue_delete(pos);
                end
            end
            default: ;
        endcase
        r.queue_count = 6'(q_len);
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            min_prio <= MIN_PRIO_RST;
            max_prio <= MAX_PRIO_RST;
            idle_prio <= IDLE_PRIO_RST;
            rt_floor <= RT_FLOOR_RST;
            skip_thr <= SKIP_THR_RST;
            seed <= SEED_RST;
            lcg = 32'd0;
            q_len = 0;
            o_errors <= 0;
            o_picks <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_PRIO:  min_prio <= i_cfg_data[6:0];
                    CFG_MAX_PRIO:  max_prio <= i_cfg_data[6:0];
                    CFG_IDLE_PRIO: idle_prio <= i_cfg_data[6:0];
                    CFG_RT_FLOOR:  rt_floor <= i_cfg_data[6:0];
                    CFG_SKIP_THR:  skip_thr <= i_cfg_data[14:0];
                    CFG_SEED:      seed <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(run_command(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat %p", i_out);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.picked_tag != 16'd0) o_picks <= o_picks + 1;
                    if (i_out !== want) begin
                        o_errors <= o_errors + 1;
                        if (i_out.picked_tag !== want.picked_tag)
                            $error("picked_tag exp %0d got %0d", want.picked_tag,
                                   i_out.picked_tag);
                        if (i_out.picked_priority !== want.picked_priority)
                            $error("picked_priority exp %0d got %0d",
                                   want.picked_priority, i_out.picked_priority);
                        if (i_out.status !== want.status)
                            $error("status exp %0d got %0d", want.status, i_out.status);
                        if (i_out.queue_count !== want.queue_count)
                            $error("queue_count exp %0d got %0d", want.queue_count,
                                   i_out.queue_count);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== test/tb_priority_run_queue_picker_unit.sv =====
// testbench top: drives commands and register writes, reports the verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_priority_run_queue_picker_unit;
    import rpq_pkg::*;

    logic        clk, rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic        in_valid, in_stall;
    t_in_item    in_beat;
    logic        out_valid, out_stall;
    t_out_item   out_beat;
    int          errors, pending, picks;
    int          sent;
    int          stall_mode;
    logic        drain_hold;

    priority_run_queue_picker_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_beat),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_beat)
    );

    rpq_scoreboard i_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_beat),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_beat),
        .o_errors(errors), .o_pending(pending), .o_picks(picks)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    // receiver stall pattern, changes style now and then
    always @(posedge clk) begin
        if (!rst_n || drain_hold) begin
            out_stall <= 1'b0;
            stall_mode <= 1;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic send_cmd(t_cmd c, logic [15:0] tag, logic [7:0] pr, logic rq);
        in_valid <= 1'b1;
        in_beat <= '{command: c, thread_tag: tag, priority_req: pr, requeue: rq};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic idle_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_burst(int count, int tag_span);
        int k, r;
        t_cmd c;
        while (count > 0) begin
            k = $urandom_range(1, 12);
            repeat (k) begin
                if (count > 0) begin
                    r = $urandom_range(0, 99);
                    c = r < 45 ? CMD_ENQUEUE : r < 62 ? CMD_REMOVE :
                        r < 98 ? CMD_RESCHED : CMD_NONE;
                    send_cmd(c, 16'($urandom_range(0, tag_span)),
                             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    count--;
                end
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_beat = '0;
        drain_hold = 1'b0;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pick, missing tag, extremes, unused command, fill to full
        send_cmd(CMD_RESCHED, 16'd5, 8'd10, 1'b0);
        send_cmd(CMD_REMOVE, 16'hFFFF, 8'd0, 1'b0);
        send_cmd(CMD_NONE, 16'hFFFF, 8'hFF, 1'b1);
        send_cmd(CMD_ENQUEUE, 16'hFFFF, 8'hFF, 1'b1);
        send_cmd(CMD_ENQUEUE, 16'h0000, 8'h00, 1'b0);
        send_cmd(CMD_ENQUEUE, 16'h1234, 8'd50, 1'b0);
        send_cmd(CMD_ENQUEUE, 16'h1234, 8'd50, 1'b0);
        send_cmd(CMD_REMOVE, 16'h1234, 8'd0, 1'b0);
        send_cmd(CMD_RESCHED, 16'hAAAA, 8'd120, 1'b1);
        send_cmd(CMD_RESCHED, 16'h5555, 8'd60, 1'b0);
        for (int i = 0; i < 32; i++) send_cmd(CMD_ENQUEUE, 16'(i + 100), 8'($urandom), 1'b0);
        send_cmd(CMD_RESCHED, 16'h7777, 8'd30, 1'b1);
        send_cmd(CMD_RESCHED, 16'h7777, 8'd30, 1'b0);

        // pause until everything has drained, receiver never stalls meanwhile
        drain_hold = 1'b1;
        wait_drained();
        drain_hold = 1'b0;

        random_burst(450, 255);
        wait_drained();

        // inverted clamp range, high threshold, all ones seed
        write_reg(CFG_MIN_PRIO, 32'd90);
        write_reg(CFG_MAX_PRIO, 32'd20);
        write_reg(CFG_IDLE_PRIO, 32'd5);
        write_reg(CFG_RT_FLOOR, 32'd127);
        write_reg(CFG_SKIP_THR, 32'h7FFF);
        write_reg(CFG_SEED, 32'hFFFF_FFFF);
        random_burst(250, 40);
        wait_drained();

        // wide range with skipping walk active
        write_reg(CFG_MIN_PRIO, 32'd0);
        write_reg(CFG_MAX_PRIO, 32'd127);
        write_reg(CFG_IDLE_PRIO, 32'd3);
        write_reg(CFG_RT_FLOOR, 32'd110);
        write_reg(CFG_SKIP_THR, 32'd20000);
        write_reg(CFG_SEED, $urandom);
        random_burst(400, 255);
        wait_drained();

        // extremes: zero threshold, top idle, zero floor
        write_reg(CFG_MIN_PRIO, 32'd127);
        write_reg(CFG_MAX_PRIO, 32'd127);
        write_reg(CFG_IDLE_PRIO, 32'd127);
        write_reg(CFG_RT_FLOOR, 32'd0);
        write_reg(CFG_SKIP_THR, 32'd0);
        write_reg(CFG_SEED, 32'd0);
        random_burst(150, 1000);
        wait_drained();

        write_reg(CFG_MIN_PRIO, 32'd1);
        write_reg(CFG_MAX_PRIO, 32'd126);
        write_reg(CFG_IDLE_PRIO, 32'd0);
        write_reg(CFG_RT_FLOOR, 32'd127);
        write_reg(CFG_SKIP_THR, 32'd30000);
        write_reg(CFG_SEED, $urandom);
        random_burst(500, 65535);
        wait_drained();

        $display("ran %0d commands over five register settings, %0d threads picked",
                 sent, picks);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
